[rtl/srcc_pkg.sv]
package srcc_pkg;

  localparam int WORD_W    = 17;
  localparam int PIECE_W   = 13;
  localparam int CHK_W     = 10;
  localparam int CNT_W     = 5;
  localparam int NUM_WORDS = 8;
  localparam int NUM_FOLD  = 7;
  localparam int VALUE_W   = 64;
  localparam int ADDR_W    = 24;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [CHK_W-1:0]   chk_t;
  typedef logic [3:0]         pos_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  localparam logic [CNT_W-1:0] COUNT_ONE = 5'd1;
  localparam pos_t CHK_LAST = 4'd9;

  // starting check bit of each folded word: (7 + 17 * k) mod 10
  localparam pos_t FOLD_POS [NUM_FOLD] = '{4'd7, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2, 4'd9};

  typedef struct packed {
    op_t                     op;
    word_t [NUM_WORDS-1:0]   w;
  } rec_t;

  typedef struct packed {
    op_t                     op;
    word_t [NUM_WORDS-1:0]   w;
    chk_t  [NUM_FOLD-1:0]    part;
  } fold_t;

  function automatic chk_t fold_word(word_t w, pos_t start);
    chk_t r;
    pos_t p;
    r = '0;
    p = start;
    for (int b = 0; b < WORD_W; b++) begin
      r[p] = r[p] ^ w[b];
      p = (p == CHK_LAST) ? 4'd0 : p + 4'd1;
    end
    return r;
  endfunction

endpackage

[rtl/slot_record_codec_with_checksum.sv]
// Slot record codec with a 10-bit check field.
// Input channel: in_valid / in_stall carry one request: opcode plus either a
// value and address (encode) or eight 17-bit record words (decode).
// Output channel: out_valid / out_stall carry one result per request: ok,
// the value and address, and the eight encoded words (zero when decoding).
// Pipeline: each request passes through three register stages, word packing,
// per-word check folding, and check combine / compare, then raises out_valid.
// Throughput: one request per cycle while the output is not stalled.
// Reset: rst (synchronous) clears all stage valid bits; no results pending.
// Stall: while out_valid is high and out_stall is high, the whole pipeline
// holds and in_stall is raised; nothing is lost or repeated. Empty output
// slots never stall the input.
module slot_record_codec_with_checksum (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             opcode,
  input  srcc_pkg::value_t in_value,
  input  srcc_pkg::addr_t  in_address,
  input  srcc_pkg::word_t  in_word0,
  input  srcc_pkg::word_t  in_word1,
  input  srcc_pkg::word_t  in_word2,
  input  srcc_pkg::word_t  in_word3,
  input  srcc_pkg::word_t  in_word4,
  input  srcc_pkg::word_t  in_word5,
  input  srcc_pkg::word_t  in_word6,
  input  srcc_pkg::word_t  in_word7,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             ok,
  output srcc_pkg::value_t out_value,
  output srcc_pkg::addr_t  out_address,
  output srcc_pkg::word_t  out_word0,
  output srcc_pkg::word_t  out_word1,
  output srcc_pkg::word_t  out_word2,
  output srcc_pkg::word_t  out_word3,
  output srcc_pkg::word_t  out_word4,
  output srcc_pkg::word_t  out_word5,
  output srcc_pkg::word_t  out_word6,
  output srcc_pkg::word_t  out_word7
);
  import srcc_pkg::*;

  logic  adv;
  logic  s1_vld;
  rec_t  s1;
  logic  s2_vld;
  fold_t s2;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  srcc_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_vld     (in_valid),
    .opcode     (opcode),
    .in_value   (in_value),
    .in_address (in_address),
    .in_word0   (in_word0),
    .in_word1   (in_word1),
    .in_word2   (in_word2),
    .in_word3   (in_word3),
    .in_word4   (in_word4),
    .in_word5   (in_word5),
    .in_word6   (in_word6),
    .in_word7   (in_word7),
    .s1_vld     (s1_vld),
    .s1         (s1)
  );

  srcc_fold u_fold (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s2_vld (s2_vld),
    .s2     (s2)
  );

  srcc_check u_check (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .s2_vld      (s2_vld),
    .s2          (s2),
    .out_valid   (out_valid),
    .ok          (ok),
    .out_value   (out_value),
    .out_address (out_address),
    .out_word0   (out_word0),
    .out_word1   (out_word1),
    .out_word2   (out_word2),
    .out_word3   (out_word3),
    .out_word4   (out_word4),
    .out_word5   (out_word5),
    .out_word6   (out_word6),
    .out_word7   (out_word7)
  );

`ifndef ASSERT_OFF
  a_encode_ok : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word0 != '0 |-> ok)
    else $error("encoded record not flagged ok");

  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> out_value == '0 && out_address == '0)
    else $error("rejected record carries data");

  a_encode_fields : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word0 != '0 |->
      out_word0[CNT_W-1:0] == COUNT_ONE && out_word2[12:10] == out_address[23:21])
    else $error("encoded record fields mismatch");
`endif

endmodule

[rtl/srcc_pack.sv]
module srcc_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic                opcode,
  input  srcc_pkg::value_t    in_value,
  input  srcc_pkg::addr_t     in_address,
  input  srcc_pkg::word_t     in_word0,
  input  srcc_pkg::word_t     in_word1,
  input  srcc_pkg::word_t     in_word2,
  input  srcc_pkg::word_t     in_word3,
  input  srcc_pkg::word_t     in_word4,
  input  srcc_pkg::word_t     in_word5,
  input  srcc_pkg::word_t     in_word6,
  input  srcc_pkg::word_t     in_word7,
  output logic                s1_vld,
  output srcc_pkg::rec_t      s1
);
  import srcc_pkg::*;

  rec_t s1_next;

  always_comb begin
    s1_next = '0;
    s1_next.op = op_t'(opcode);
    case (op_t'(opcode))
      OP_ENCODE: begin
        s1_next.w[0] = {4'b0, in_address[7:0], COUNT_ONE};
        s1_next.w[1] = {4'b0, in_address[20:8]};
        s1_next.w[2] = {4'b0, in_address[23:21], 10'b0};
        for (int i = 0; i < 4; i++) begin
          s1_next.w[3+i] = {4'b0, in_value[PIECE_W*i +: PIECE_W]};
        end
        s1_next.w[7] = {5'b0, in_value[63:52]};
      end
      OP_DECODE: begin
        s1_next.w = {in_word7, in_word6, in_word5, in_word4,
                     in_word3, in_word2, in_word1, in_word0};
      end
      default: begin
        s1_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
    end
  end

endmodule

[rtl/srcc_fold.sv]
module srcc_fold (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            s1_vld,
  input  srcc_pkg::rec_t  s1,
  output logic            s2_vld,
  output srcc_pkg::fold_t s2
);
  import srcc_pkg::*;

  fold_t s2_next;

  always_comb begin
    s2_next.op = s1.op;
    s2_next.w  = s1.w;
    for (int k = 0; k < NUM_FOLD; k++) begin
      s2_next.part[k] = fold_word(s1.w[(k < 2) ? k : k + 1], FOLD_POS[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
    end
  end

endmodule

[rtl/srcc_check.sv]
module srcc_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                s2_vld,
  input  srcc_pkg::fold_t     s2,
  output logic                out_valid,
  output logic                ok,
  output srcc_pkg::value_t    out_value,
  output srcc_pkg::addr_t     out_address,
  output srcc_pkg::word_t     out_word0,
  output srcc_pkg::word_t     out_word1,
  output srcc_pkg::word_t     out_word2,
  output srcc_pkg::word_t     out_word3,
  output srcc_pkg::word_t     out_word4,
  output srcc_pkg::word_t     out_word5,
  output srcc_pkg::word_t     out_word6,
  output srcc_pkg::word_t     out_word7
);
  import srcc_pkg::*;

  chk_t                  chk;
  logic                  good;
  value_t                value;
  addr_t                 addr;
  logic                  ok_next;
  value_t                value_next;
  addr_t                 addr_next;
  word_t [NUM_WORDS-1:0] words_next;

  always_comb begin
    chk = {3'b0, s2.w[2][16:10]};
    for (int k = 0; k < NUM_FOLD; k++) begin
      chk = chk ^ s2.part[k];
    end
    good  = (s2.w[2][CHK_W-1:0] == chk) && (s2.w[0][CNT_W-1:0] == COUNT_ONE);
    addr  = {s2.w[2][12:10], s2.w[1][12:0], s2.w[0][12:5]};
    value = {s2.w[7][11:0], s2.w[6][12:0], s2.w[5][12:0],
             s2.w[4][12:0], s2.w[3][12:0]};
    case (s2.op)
      OP_ENCODE: begin
        ok_next       = 1'b1;
        value_next    = value;
        addr_next     = addr;
        words_next    = s2.w;
        words_next[2] = s2.w[2] | {7'b0, chk};
      end
      OP_DECODE: begin
        ok_next    = good;
        value_next = good ? value : '0;
        addr_next  = good ? addr : '0;
        words_next = '0;
      end
      default: begin
        ok_next    = 1'b0;
        value_next = '0;
        addr_next  = '0;
        words_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok          <= ok_next;
      out_value   <= value_next;
      out_address <= addr_next;
      out_word0   <= words_next[0];
      out_word1   <= words_next[1];
      out_word2   <= words_next[2];
      out_word3   <= words_next[3];
      out_word4   <= words_next[4];
      out_word5   <= words_next[5];
      out_word6   <= words_next[6];
      out_word7   <= words_next[7];
    end
  end

endmodule
